// ===== design/ffa_pkg.sv =====
`timescale 1ns / 1ps
// ffa_pkg: command and status codes, header constants and the statistics
// event type shared by the first-fit allocator modules. No dependencies.
package ffa_pkg;

    // header size in bytes and the alignment mask
    localparam int unsigned HDR_BYTES  = 16;
    localparam logic [31:0] ALIGN_MASK = 32'd15;
    // largest request that can still be rounded up within 32 bits
    localparam logic [31:0] MAX_REQ    = 32'hFFFF_FFF0;
    // width of a rounded request counted in headers
    localparam int unsigned NEED_W     = 28;

    // commands
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_RESET   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ALLOC_OK  = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_FREED     = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;
    localparam logic [2:0] ST_UNMATCHED = 3'd5;
    localparam logic [2:0] ST_RESET     = 3'd6;

    // one update for the statistics counters
    typedef struct packed {
        logic        clear;
        logic        grant;
        logic        fail;
        logic        release_seen;
        logic        reject;
        logic [31:0] size;
    } t_stat_ev;

endpackage

// ===== design/ffa_ifs.sv =====
`timescale 1ns / 1ps
// ffa_ifs: valid/ready channel interfaces for request and result words
// of the first-fit allocator. No dependencies.
interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] request_size;
    logic [31:0] release_address;

    modport source (output valid, output cmd, output request_size,
                    output release_address, input ready);
    modport sink   (input valid, input cmd, input request_size,
                    input release_address, output ready);
endinterface

interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] granted_address;
    logic [16:0] used_bytes;
    logic [16:0] peak_bytes;
    logic [31:0] grant_count;
    logic [31:0] largest_request;
    logic [31:0] failed_request;
    logic [31:0] release_count;
    logic [31:0] unmatched_count;

    modport source (output valid, output status, output granted_address,
                    output used_bytes, output peak_bytes, output grant_count,
                    output largest_request, output failed_request,
                    output release_count, output unmatched_count, input ready);
    modport sink   (input valid, input status, input granted_address,
                    input used_bytes, input peak_bytes, input grant_count,
                    input largest_request, input failed_request,
                    input release_count, input unmatched_count, output ready);
endinterface

// ===== design/ffa_hdr_mem.sv =====
`timescale 1ns / 1ps
// ffa_hdr_mem: header table storage, one write port and one read port
// with registered read data. No dependencies.
module ffa_hdr_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 40
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/ffa_stats.sv =====
`timescale 1ns / 1ps
// ffa_stats: grant, release and reject counters, the largest granted size and
// the size of the last failed request of the allocator. Depends on ffa_pkg.
module ffa_stats (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffa_pkg::t_stat_ev i_ev,
    output logic [31:0]       o_grants,
    output logic [31:0]       o_largest,
    output logic [31:0]       o_failed,
    output logic [31:0]       o_releases,
    output logic [31:0]       o_rejected
);
    import ffa_pkg::*;

    logic [31:0] r_grants, r_largest, r_failed, r_releases, r_rejected;

    // counter updates, cleared by reset or by the arena reset command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ev.clear) begin
            r_grants   <= '0;
            r_largest  <= '0;
            r_failed   <= '0;
            r_releases <= '0;
            r_rejected <= '0;
        end else begin
            if (i_ev.grant) begin
                r_grants <= r_grants + 32'd1;
                if (i_ev.size > r_largest) begin
                    r_largest <= i_ev.size;
                end
            end
            if (i_ev.fail) begin
                r_failed <= i_ev.size;
            end
            if (i_ev.release_seen) begin
                r_releases <= r_releases + 32'd1;
            end
            if (i_ev.reject) begin
                r_rejected <= r_rejected + 32'd1;
            end
        end
    end

    assign o_grants   = r_grants;
    assign o_largest  = r_largest;
    assign o_failed   = r_failed;
    assign o_releases = r_releases;
    assign o_rejected = r_rejected;
endmodule

// ===== design/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// first_fit_block_allocator: first-fit arena allocator with 16-byte headers,
// block splitting and merging on release. Depends on ffa_pkg, ffa_ifs,
// ffa_hdr_mem and ffa_stats.
//
// One word is handled at a time; the header table is a single memory with
// one write and one registered read port. An allocate walks the chain from
// the first header until a header fits or ends the chain; a split then
// writes the remainder block and relinks the following block. Oversize,
// null and unused commands go straight to the result. A release is rejected
// outright on its address or by the header check, or frees the block and
// merges free neighbours. After i_rst_n and after the arena reset command
// the table is swept once before the next word is taken. A finished result
// sits in an output register, so a new word is taken while it waits; a
// second result stalls until the first is taken.
module first_fit_block_allocator #(
    parameter int ARENA_BYTES = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ffa_req_if.sink   i_req,
    ffa_rsp_if.source o_rsp
);
    import ffa_pkg::*;

    localparam int SLOTS = ARENA_BYTES / HDR_BYTES;
    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(ARENA_BYTES);

    typedef struct packed {
        logic          valid;
        logic          free;
        logic          has_next;
        logic          has_prev;
        logic [SW-1:0] size;
        logic [SW-1:0] nxt;
        logic [SW-1:0] prv;
    } t_hdr;

    localparam int EW = $bits(t_hdr);

    typedef enum logic [11:0] {
        S_CLR  = 12'b0000_0000_0001,
        S_IDLE = 12'b0000_0000_0010,
        S_WALK = 12'b0000_0000_0100,
        S_ASP  = 12'b0000_0000_1000,
        S_RB   = 12'b0000_0001_0000,
        S_RN   = 12'b0000_0010_0000,
        S_RP   = 12'b0000_0100_0000,
        S_WB   = 12'b0000_1000_0000,
        S_ZERO = 12'b0001_0000_0000,
        S_FIXR = 12'b0010_0000_0000,
        S_FIXW = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [SW-1:0]     r_clr, n_clr;
    logic              r_boot, n_boot;
    logic [SW-1:0]     r_cur, n_cur;
    t_hdr              r_blk, n_blk;
    logic [NEED_W-1:0] r_need, n_need;
    logic [31:0]       r_size, n_size;
    logic              r_merged, n_merged;
    logic [SW-1:0]     r_fix_at, n_fix_at;
    logic [SW-1:0]     r_owner, n_owner;
    logic [LW-1:0]     r_live, n_live;
    logic [LW-1:0]     r_peak, n_peak;
    logic [2:0]        r_status, n_status;
    logic [15:0]       r_grant, n_grant;

    // output register
    logic        r_ov;
    logic [2:0]  r_o_status;
    logic [15:0] r_o_grant;
    logic [16:0] r_o_used, r_o_peak;
    logic [31:0] r_o_grants, r_o_largest, r_o_failed, r_o_releases, r_o_rejected;

    // memory port
    logic          mem_we;
    logic [SW-1:0] mem_waddr, mem_raddr;
    t_hdr          mem_wdata, rd;
    logic [EW-1:0] mem_rdata;

    t_stat_ev    ev;
    logic [31:0] st_grants, st_largest, st_failed, st_releases, st_rejected;

    logic              accept, load_out;
    logic [31:0]       req_sz;
    logic [LW:0]       pay_addr;
    logic              fits, split;
    logic [SW-1:0]     need_s, split_at, rel_blk;
    logic [LW-1:0]     blk_bytes;

    ffa_hdr_mem #(.DEPTH(SLOTS), .AW(SW), .DW(EW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ffa_stats u_stats (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev       (ev),
        .o_grants   (st_grants),
        .o_largest  (st_largest),
        .o_failed   (st_failed),
        .o_releases (st_releases),
        .o_rejected (st_rejected)
    );

    assign rd           = t_hdr'(mem_rdata);
    assign i_req.ready  = (r_state == S_IDLE);
    assign accept       = i_req.valid && i_req.ready;
    assign load_out     = (r_state == S_OUT) && (!r_ov || o_rsp.ready);

    // helpers for the walk and the release
    assign req_sz    = (i_req.request_size == 32'd0) ? 32'd1 : i_req.request_size;
    assign need_s    = SW'(r_need);
    assign fits      = rd.free && (32'(rd.size) >= 32'(r_need));
    assign split     = 32'(rd.size) >= (32'(r_need) + 32'd2);
    assign split_at  = r_cur + SW'(1) + need_s;
    assign pay_addr  = {1'b0, r_cur, 4'b0000} + (LW+1)'(HDR_BYTES);
    assign blk_bytes = {rd.size, 4'b0000};
    assign rel_blk   = SW'(i_req.release_address[31:4] - 28'd1);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_boot    = r_boot;
        n_cur     = r_cur;
        n_blk     = r_blk;
        n_need    = r_need;
        n_size    = r_size;
        n_merged  = r_merged;
        n_fix_at  = r_fix_at;
        n_owner   = r_owner;
        n_live    = r_live;
        n_peak    = r_peak;
        n_status  = r_status;
        n_grant   = r_grant;
        mem_we    = 1'b0;
        mem_waddr = r_cur;
        mem_wdata = '0;
        mem_raddr = r_cur;
        ev        = '0;
        ev.size   = r_size;

        case (r_state)
            // sweep the table, leaving one free block at entry zero
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == '0) begin
                    mem_wdata.valid = 1'b1;
                    mem_wdata.free  = 1'b1;
                    mem_wdata.size  = SW'(SLOTS - 1);
                end
                if (r_clr == SW'(SLOTS - 1)) begin
                    n_boot = 1'b0;
                    if (r_boot) begin
                        n_status = ST_RESET;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_clr = r_clr + SW'(1);
                end
            end

            // decode a new word
            S_IDLE: begin
                if (accept) begin
                    n_grant = '0;
                    case (i_req.cmd)
                        CMD_ALLOC: begin
                            if (req_sz > MAX_REQ) begin
                                n_status = ST_TOO_LARGE;
                                n_state  = S_OUT;
                            end else begin
                                n_size    = req_sz;
                                n_need    = NEED_W'((req_sz + ALIGN_MASK) >> 4);
                                n_cur     = '0;
                                mem_raddr = '0;
                                n_state   = S_WALK;
                            end
                        end
                        CMD_RELEASE: begin
                            if (i_req.release_address == 32'd0) begin
                                n_status = ST_IGNORED;
                                n_state  = S_OUT;
                            end else begin
                                ev.release_seen = 1'b1;
                                if (i_req.release_address < 32'(HDR_BYTES) ||
                                    i_req.release_address >= 32'(ARENA_BYTES) ||
                                    (i_req.release_address & ALIGN_MASK) != 32'd0) begin
                                    ev.reject = 1'b1;
                                    n_status  = ST_UNMATCHED;
                                    n_state   = S_OUT;
                                end else begin
                                    n_cur     = rel_blk;
                                    mem_raddr = rel_blk;
                                    n_state   = S_RB;
                                end
                            end
                        end
                        CMD_RESET: begin
                            ev.clear = 1'b1;
                            n_live   = '0;
                            n_peak   = '0;
                            n_clr    = '0;
                            n_boot   = 1'b1;
                            n_state  = S_CLR;
                        end
                        default: begin
                            n_status = ST_IGNORED;
                            n_state  = S_OUT;
                        end
                    endcase
                end
            end

            // one header of the chain per cycle
            S_WALK: begin
                if (!rd.valid || (!fits && !rd.has_next)) begin
                    ev.fail  = 1'b1;
                    n_status = ST_NO_FIT;
                    n_state  = S_OUT;
                end else if (fits) begin
                    ev.grant  = 1'b1;
                    n_status  = ST_ALLOC_OK;
                    n_grant   = 16'(pay_addr);
                    mem_we    = 1'b1;
                    mem_waddr = r_cur;
                    mem_wdata = rd;
                    mem_wdata.free = 1'b0;
                    if (split) begin
                        mem_wdata.has_next = 1'b1;
                        mem_wdata.nxt      = split_at;
                        mem_wdata.size     = need_s;
                        n_live   = r_live + {need_s, 4'b0000};
                        n_blk    = rd;
                        n_owner  = split_at;
                        n_fix_at = rd.nxt;
                        n_state  = S_ASP;
                    end else begin
                        n_live  = r_live + blk_bytes;
                        n_state = S_OUT;
                    end
                    if (n_live > r_peak) begin
                        n_peak = n_live;
                    end
                end else begin
                    n_cur     = rd.nxt;
                    mem_raddr = rd.nxt;
                end
            end

            // write the remainder block of a split
            S_ASP: begin
                mem_we             = 1'b1;
                mem_waddr          = r_owner;
                mem_wdata.valid    = 1'b1;
                mem_wdata.free     = 1'b1;
                mem_wdata.has_next = r_blk.has_next;
                mem_wdata.has_prev = 1'b1;
                mem_wdata.size     = r_blk.size - need_s - SW'(1);
                mem_wdata.nxt      = r_blk.nxt;
                mem_wdata.prv      = r_cur;
                n_state = r_blk.has_next ? S_FIXR : S_OUT;
            end

            // check the block being released
            S_RB: begin
                if (!rd.valid || rd.free || blk_bytes > r_live) begin
                    ev.reject = 1'b1;
                    n_status  = ST_UNMATCHED;
                    n_state   = S_OUT;
                end else begin
                    n_status = ST_FREED;
                    n_live   = r_live - blk_bytes;
                    n_blk    = rd;
                    n_blk.free = 1'b1;
                    n_merged = 1'b0;
                    if (rd.has_next) begin
                        mem_raddr = rd.nxt;
                        n_state   = S_RN;
                    end else if (rd.has_prev) begin
                        mem_raddr = rd.prv;
                        n_state   = S_RP;
                    end else begin
                        n_state = S_WB;
                    end
                end
            end

            // merge with a free next block
            S_RN: begin
                if (rd.free) begin
                    n_blk.size     = r_blk.size + SW'(1) + rd.size;
                    n_blk.nxt      = rd.nxt;
                    n_blk.has_next = rd.has_next;
                    n_merged       = 1'b1;
                    mem_we         = 1'b1;
                    mem_waddr      = r_blk.nxt;
                end
                if (r_blk.has_prev) begin
                    mem_raddr = r_blk.prv;
                    n_state   = S_RP;
                end else begin
                    n_state = S_WB;
                end
            end

            // merge into a free previous block
            S_RP: begin
                if (rd.free) begin
                    mem_we             = 1'b1;
                    mem_waddr          = r_blk.prv;
                    mem_wdata          = rd;
                    mem_wdata.size     = rd.size + SW'(1) + r_blk.size;
                    mem_wdata.nxt      = r_blk.nxt;
                    mem_wdata.has_next = r_blk.has_next;
                    n_owner  = r_blk.prv;
                    n_fix_at = r_blk.nxt;
                    n_state  = S_ZERO;
                end else begin
                    n_state = S_WB;
                end
            end

            // drop the released header after merging backwards
            S_ZERO: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                n_state   = r_blk.has_next ? S_FIXR : S_OUT;
            end

            // write back the released block
            S_WB: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = r_blk;
                if (r_merged && r_blk.has_next) begin
                    n_fix_at = r_blk.nxt;
                    n_owner  = r_cur;
                    n_state  = S_FIXR;
                end else begin
                    n_state = S_OUT;
                end
            end

            // relink the back pointer of the following block
            S_FIXR: begin
                mem_raddr = r_fix_at;
                n_state   = S_FIXW;
            end

            S_FIXW: begin
                mem_we    = 1'b1;
                mem_waddr = r_fix_at;
                mem_wdata = rd;
                mem_wdata.has_prev = 1'b1;
                mem_wdata.prv      = r_owner;
                n_state = S_OUT;
            end

            // hand the result to the output register
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_boot  <= 1'b0;
            r_live  <= '0;
            r_peak  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_boot  <= n_boot;
            r_live  <= n_live;
            r_peak  <= n_peak;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_blk    <= n_blk;
        r_need   <= n_need;
        r_size   <= n_size;
        r_merged <= n_merged;
        r_fix_at <= n_fix_at;
        r_owner  <= n_owner;
        r_status <= n_status;
        r_grant  <= n_grant;
        if (load_out) begin
            r_o_status   <= r_status;
            r_o_grant    <= r_grant;
            r_o_used     <= 17'(r_live);
            r_o_peak     <= 17'(r_peak);
            r_o_grants   <= st_grants;
            r_o_largest  <= st_largest;
            r_o_failed   <= st_failed;
            r_o_releases <= st_releases;
            r_o_rejected <= st_rejected;
        end
    end

    assign o_rsp.valid           = r_ov;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.granted_address = r_o_grant;
    assign o_rsp.used_bytes      = r_o_used;
    assign o_rsp.peak_bytes      = r_o_peak;
    assign o_rsp.grant_count     = r_o_grants;
    assign o_rsp.largest_request = r_o_largest;
    assign o_rsp.failed_request  = r_o_failed;
    assign o_rsp.release_count   = r_o_releases;
    assign o_rsp.unmatched_count = r_o_rejected;
endmodule
